### rtl/core/led_driver_serial_sender_core_macros.svh
// Assertion macros used by the LED serial sender top level.
`ifndef LED_DRIVER_SERIAL_SENDER_CORE_MACROS_SVH
`define LED_DRIVER_SERIAL_SENDER_CORE_MACROS_SVH

// Same-cycle implication, clocked by clock, off during reset.
`define LEDSS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ledss assertion failed");

// Next-cycle implication, clocked by clock, off during reset.
`define LEDSS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ledss assertion failed");

`endif

### rtl/core/ledss_pkg.sv
// Types, constants and microcode ROM for the LED serial sender.
package ledss_pkg;

   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_BRIGHT = 2'd1;
   localparam logic [1:0] CMD_GRID   = 2'd2;

   localparam logic [2:0] CSR_GRID_MAP_EN    = 3'd0;
   localparam logic [2:0] CSR_GRID_MAP_LOWER = 3'd1;
   localparam logic [2:0] CSR_GRID_MAP_UPPER = 3'd2;
   localparam logic [2:0] CSR_SEG_MAP_EN     = 3'd3;
   localparam logic [2:0] CSR_SEG_MAP        = 3'd4;

   localparam int CSR_DATA_W = 40;

   localparam logic [7:0] BYTE_DATA_AUTO = 8'h40;
   localparam logic [7:0] BYTE_DISP_OFF  = 8'h80;
   localparam logic [7:0] BYTE_DISP_ON   = 8'h88;
   localparam logic [7:0] BYTE_ADDR      = 8'hC0;
   localparam logic [4:0] BRIGHT_MAX     = 5'd8;

   typedef logic [3:0] pc_type;

   localparam pc_type PC_BEGIN = 4'd0;
   localparam pc_type PC_START = 4'd2;
   localparam pc_type PC_BIT   = 4'd3;

   typedef enum logic [1:0] {CLK_KEEP, CLK_LOW, CLK_HIGH} clk_op_type;
   typedef enum logic [1:0] {DAT_KEEP, DAT_LOW, DAT_HIGH, DAT_BIT} dat_op_type;
   typedef enum logic {COND_NONE, COND_BYTE_LOOP} cond_type;

   typedef struct packed {
      clk_op_type clk_op;
      dat_op_type dat_op;
      logic       hold;
      logic       last;
      cond_type   cond;
      pc_type     target;
   } ucode_type;

   typedef struct packed {
      logic      fire;
      ucode_type word;
   } seq_ctrl_type;

   typedef struct packed {
      logic slot_free;
      logic loop_taken;
   } dp_status_type;

   typedef struct packed {
      logic       start;
      pc_type     entry;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       two_bytes;
   } load_type;

   // Frame program: begin prefix, start, byte loop, stop.
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      w = '{clk_op: CLK_KEEP, dat_op: DAT_KEEP, hold: 1'b0, last: 1'b0,
            cond: COND_NONE, target: PC_BIT};
      unique case (pc)
         4'd0: begin w.clk_op = CLK_HIGH; w.dat_op = DAT_HIGH; end
         4'd1: begin w.clk_op = CLK_HIGH; w.hold = 1'b1; end
         4'd2: begin w.dat_op = DAT_LOW; w.hold = 1'b1; end
         4'd3: begin w.clk_op = CLK_LOW; end
         4'd4: begin w.dat_op = DAT_BIT; end
         4'd5: begin
            w.clk_op = CLK_HIGH;
            w.hold   = 1'b1;
            w.cond   = COND_BYTE_LOOP;
         end
         4'd6: begin w.clk_op = CLK_LOW; end
         4'd7: begin w.dat_op = DAT_LOW; end
         4'd8: begin w.clk_op = CLK_HIGH; w.hold = 1'b1; end
         4'd9: begin w.dat_op = DAT_HIGH; w.hold = 1'b1; w.last = 1'b1; end
         default: begin w.dat_op = DAT_HIGH; w.hold = 1'b1; w.last = 1'b1; end
      endcase
      return w;
   endfunction

endpackage

### rtl/core/ledss_if.sv
// Request and response channel interfaces.
interface ledss_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic signed [4:0] brightness;
   logic [7:0]        grid;
   logic [7:0]        segs;

   modport source (output valid, command, brightness, grid, segs, input ready);
   modport sink   (input valid, command, brightness, grid, segs, output ready);
endinterface

interface ledss_rsp_if;
   logic valid;
   logic ready;
   logic clock_level;
   logic data_level;
   logic hold_after;
   logic last_step;

   modport source (output valid, clock_level, data_level, hold_after, last_step,
                   input ready);
   modport sink   (input valid, clock_level, data_level, hold_after, last_step,
                   output ready);
endinterface

### rtl/core/ledss_seq.sv
// Microcode sequencer: step counter, ROM fetch and conditional jump.
module ledss_seq
   import ledss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  load_type      load,
   input  dp_status_type status,
   output seq_ctrl_type  ctrl,
   output logic          busy
);

   logic      busy_ff, busy_in;
   pc_type    pc_ff, pc_in;
   ucode_type word;
   logic      fire;

   always_comb begin
      word    = ucode_rom(pc_ff);
      fire    = busy_ff && status.slot_free;
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (load.start) begin
         busy_in = 1'b1;
         pc_in   = load.entry;
      end else if (fire) begin
         if (word.last) busy_in = 1'b0;
         if (word.cond == COND_BYTE_LOOP && status.loop_taken) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_BEGIN;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign ctrl.fire = fire;
   assign ctrl.word = word;
   assign busy      = busy_ff;

endmodule

### rtl/core/ledss_datapath.sv
// Datapath: pin levels, byte shifter and result register.
module ledss_datapath
   import ledss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  load_type      load,
   input  seq_ctrl_type  ctrl,
   output dp_status_type status,
   ledss_rsp_if.source   rsp_ch
);

   logic       clk_ff, clk_in;
   logic       dat_ff, dat_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] byte1_ff, byte1_in;
   logic       pending_ff, pending_in;
   logic [2:0] bitcnt_ff, bitcnt_in;
   logic       valid_ff, valid_in;
   logic       out_clk_ff, out_dat_ff, out_hold_ff, out_last_ff;
   logic       slot_free;
   logic       loop_taken;

   assign slot_free  = !valid_ff || rsp_ch.ready;
   assign loop_taken = (bitcnt_ff != 3'd7) || pending_ff;

   always_comb begin
      clk_in     = clk_ff;
      dat_in     = dat_ff;
      shift_in   = shift_ff;
      byte1_in   = byte1_ff;
      pending_in = pending_ff;
      bitcnt_in  = bitcnt_ff;
      valid_in   = valid_ff && !rsp_ch.ready;
      if (load.start) begin
         // lines idle high at the start of every request
         clk_in     = 1'b1;
         dat_in     = 1'b1;
         shift_in   = load.byte0;
         byte1_in   = load.byte1;
         pending_in = load.two_bytes;
         bitcnt_in  = 3'd0;
      end else if (ctrl.fire) begin
         valid_in = 1'b1;
         unique case (ctrl.word.clk_op)
            CLK_LOW:  clk_in = 1'b0;
            CLK_HIGH: clk_in = 1'b1;
            default:  clk_in = clk_ff;
         endcase
         unique case (ctrl.word.dat_op)
            DAT_KEEP: dat_in = dat_ff;
            DAT_LOW:  dat_in = 1'b0;
            DAT_HIGH: dat_in = 1'b1;
            DAT_BIT:  dat_in = shift_ff[0];
         endcase
         if (ctrl.word.cond == COND_BYTE_LOOP) begin
            if (bitcnt_ff != 3'd7) begin
               shift_in  = {1'b0, shift_ff[7:1]};
               bitcnt_in = bitcnt_ff + 3'd1;
            end else if (pending_ff) begin
               shift_in   = byte1_ff;
               pending_in = 1'b0;
               bitcnt_in  = 3'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff     <= 1'b1;
         dat_ff     <= 1'b1;
         pending_ff <= 1'b0;
         bitcnt_ff  <= 3'd0;
         valid_ff   <= 1'b0;
      end else begin
         clk_ff     <= clk_in;
         dat_ff     <= dat_in;
         pending_ff <= pending_in;
         bitcnt_ff  <= bitcnt_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      byte1_ff <= byte1_in;
      if (ctrl.fire) begin
         out_clk_ff  <= clk_in;
         out_dat_ff  <= dat_in;
         out_hold_ff <= ctrl.word.hold;
         out_last_ff <= ctrl.word.last;
      end
   end

   assign status.slot_free  = slot_free;
   assign status.loop_taken = loop_taken;

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.clock_level = out_clk_ff;
   assign rsp_ch.data_level  = out_dat_ff;
   assign rsp_ch.hold_after  = out_hold_ff;
   assign rsp_ch.last_step   = out_last_ff;

endmodule

### rtl/core/led_driver_serial_sender_core.sv
// Two-wire LED driver serial sender: top level with decode and registers.
// Each accepted request becomes a frame of pin-step beats on rsp_ch, one
// beat per cycle while the sink is ready: begin gives 31 beats, set
// brightness 29, write grid 53; the last beat carries last_step. A request
// is taken whenever it is offered while idle; its frame follows from a
// microcoded sequencer (ten-word ROM, one word per beat). Requests that
// give no frame (command three, grid out of range, invalid remap entry)
// are taken and dropped. req_ch.ready is low while a frame is being sent.
// The user must write registers through csr_we/csr_index/csr_wdata only
// while idle; the block does not enforce this. There is no clearing pass
// after reset.
module led_driver_serial_sender_core
   import ledss_pkg::*;
#(
   parameter int GRID_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   ledss_req_if.sink             req_ch,
   ledss_rsp_if.source           rsp_ch,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // grid limits in the widths they are compared at
   localparam logic [7:0] GridLimit   = 8'(GRID_COUNT);
   localparam logic [4:0] EntryLimit  = 5'(GRID_COUNT);

   // configuration registers
   logic        grid_map_en_ff;
   logic [39:0] grid_map_lower_ff;
   logic [39:0] grid_map_upper_ff;
   logic        seg_map_en_ff;
   logic [23:0] seg_map_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_map_en_ff    <= 1'b0;
         grid_map_lower_ff <= '0;
         grid_map_upper_ff <= '0;
         seg_map_en_ff     <= 1'b0;
         seg_map_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_MAP_EN:    grid_map_en_ff    <= csr_wdata[0];
            CSR_GRID_MAP_LOWER: grid_map_lower_ff <= csr_wdata[39:0];
            CSR_GRID_MAP_UPPER: grid_map_upper_ff <= csr_wdata[39:0];
            CSR_SEG_MAP_EN:     seg_map_en_ff     <= csr_wdata[0];
            CSR_SEG_MAP:        seg_map_ff        <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // request decode
   logic [15:0][4:0] grid_table;
   logic [7:0][2:0]  seg_table;
   logic [4:0]       grid_entry;
   logic [3:0]       grid_addr;
   logic             grid_ok;
   logic [7:0]       segs_mapped;
   logic [7:0]       segs_out;
   logic [4:0]       bright_sat;
   logic [2:0]       bright_m1;
   logic [7:0]       bright_byte;
   logic             frame_go;
   logic             accept;
   logic             busy;
   load_type         load;
   seq_ctrl_type     ctrl;
   dp_status_type    status;

   assign grid_table = {grid_map_upper_ff, grid_map_lower_ff};
   assign seg_table  = seg_map_ff;

   always_comb begin
      grid_entry = grid_table[req_ch.grid[3:0]];
      grid_ok    = req_ch.grid < GridLimit;
      grid_addr  = req_ch.grid[3:0];
      if (grid_map_en_ff) begin
         grid_ok   = grid_ok && (grid_entry < EntryLimit);
         grid_addr = grid_entry[3:0];
      end

      // colliding targets simply OR together
      segs_mapped = '0;
      for (int i = 0; i < 8; i++) begin
         if (req_ch.segs[i]) segs_mapped = segs_mapped | (8'd1 << seg_table[i]);
      end
      segs_out = seg_map_en_ff ? segs_mapped : req_ch.segs;

      // saturate to 0..8; 0 turns the display off
      if (req_ch.brightness[4]) begin
         bright_sat = 5'd0;
      end else if (req_ch.brightness > $signed(BRIGHT_MAX)) begin
         bright_sat = BRIGHT_MAX;
      end else begin
         bright_sat = req_ch.brightness;
      end
      bright_m1   = 3'(bright_sat - 5'd1);
      bright_byte = (bright_sat == 5'd0) ? BYTE_DISP_OFF : (BYTE_DISP_ON | {5'd0, bright_m1});
   end

   assign req_ch.ready = !busy;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      frame_go       = 1'b0;
      load.entry     = PC_START;
      load.byte0     = BYTE_DATA_AUTO;
      load.byte1     = segs_out;
      load.two_bytes = 1'b0;
      unique case (req_ch.command)
         CMD_BEGIN: begin
            frame_go   = 1'b1;
            load.entry = PC_BEGIN;
         end
         CMD_BRIGHT: begin
            frame_go   = 1'b1;
            load.byte0 = bright_byte;
         end
         CMD_GRID: begin
            frame_go       = grid_ok;
            load.byte0     = BYTE_ADDR | {4'd0, grid_addr};
            load.two_bytes = 1'b1;
         end
         default: frame_go = 1'b0;
      endcase
      load.start = accept && frame_go;
   end

   ledss_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   ledss_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .ctrl   (ctrl),
      .status (status),
      .rsp_ch (rsp_ch)
   );

`include "led_driver_serial_sender_core_macros.svh"

   // a frame ends with both lines released high
   `LEDSS_ASSERT_IMP(a_last_idle_high, rsp_ch.valid && rsp_ch.last_step,
                     rsp_ch.clock_level && rsp_ch.data_level)
   // steps with the clock low never ask for a hold
   `LEDSS_ASSERT_IMP(a_clk_low_no_hold, rsp_ch.valid && !rsp_ch.clock_level,
                     !rsp_ch.hold_after)
   // the sequencer goes idle right after it issues the final beat
   `LEDSS_ASSERT_NEXT(a_last_seq_idle, ctrl.fire && ctrl.word.last, !busy)
   // a request that starts a frame blocks the next one
   `LEDSS_ASSERT_NEXT(a_start_blocks, load.start, !req_ch.ready)

endmodule

### bench/testbench.sv
// Self-checking bench for the LED driver serial sender: predicts pin-step beats per request.
module testbench
   import ledss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Command three carries no meaning; the block takes it and drops it.
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam int          GRID_SPAN     = 16;
   localparam int          SETTLE_CYCLES = 8;   // margin after the owed beats for a dropped request
   localparam int          HOLD_OFF      = 300; // long receiver stall for the pressure test
   // Worst run: ~280 requests x 53 beats, each beat behind the longest stall,
   // plus sender gaps and the hold-off; take ~3x of that.
   localparam int unsigned LIMIT_CYCLES  = 2_000_000;

   typedef struct packed {
      logic clock_level;
      logic data_level;
      logic hold_after;
      logic last_step;
   } pin_step_type;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [2:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ledss_req_if req_ch ();
   ledss_rsp_if rsp_ch ();

   led_driver_serial_sender_core #(
      .GRID_COUNT (GRID_SPAN)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the map registers, updated on every write.
   logic        map_grid_en;
   logic [39:0] grid_tbl_lo;
   logic [39:0] grid_tbl_hi;
   logic        map_seg_en;
   logic [23:0] seg_tbl;

   // Beats still owed by the block, oldest first.
   pin_step_type pending_steps[$];

   // Pin levels as the predictor walks through one frame.
   logic pin_clk;
   logic pin_dat;

   int unsigned gap_ahead = 1;   // idle cycles before the next request is offered
   bit          sender_idle = 1'b1;
   bit          drain_idle  = 1'b1;
   int unsigned hold_cycles = 0; // nonzero asks the receiver for one long stall
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Frame predictor
   // ------------------------------------------------------------------

   function automatic void put_step(input logic hold);
      pending_steps.push_back('{pin_clk, pin_dat, hold, 1'b0});
   endfunction

   // Start condition: data falls while clock is high.
   function automatic void put_start();
      pin_dat = 1'b0;
      put_step(1'b1);
   endfunction

   // LSB first, three beats per bit: clock low, data, clock high.
   function automatic void put_byte(input logic [7:0] value);
      for (int i = 0; i < 8; i++) begin
         pin_clk = 1'b0;
         put_step(1'b0);
         pin_dat = value[i];
         put_step(1'b0);
         pin_clk = 1'b1;
         put_step(1'b1);
      end
   endfunction

   // Stop condition; the final beat of every frame returns both lines high.
   function automatic void put_stop();
      pin_clk = 1'b0;
      put_step(1'b0);
      pin_dat = 1'b0;
      put_step(1'b0);
      pin_clk = 1'b1;
      put_step(1'b1);
      pin_dat = 1'b1;
      pending_steps.push_back('{pin_clk, pin_dat, 1'b1, 1'b1});
   endfunction

   function automatic void predict_frame(input logic [1:0] cmd, input logic signed [4:0] bri,
                                         input logic [7:0] grid, input logic [7:0] segs);
      int          level;
      logic [39:0] tbl;
      logic [4:0]  entry;
      logic [3:0]  addr;
      logic [7:0]  seg_out;
      // Lines are idle high going into every request.
      pin_clk = 1'b1;
      pin_dat = 1'b1;
      case (cmd)
         CMD_BEGIN: begin
            put_step(1'b0);
            put_step(1'b1);
            put_start();
            put_byte(BYTE_DATA_AUTO);
            put_stop();
         end
         CMD_BRIGHT: begin
            level = bri;
            if (level < 0) level = 0;
            if (level > 8) level = 8;
            put_start();
            put_byte(level == 0 ? BYTE_DISP_OFF : (BYTE_DISP_ON | 8'(level - 1)));
            put_stop();
         end
         CMD_GRID: begin
            if (grid >= GRID_SPAN) return;
            addr = grid[3:0];
            if (map_grid_en) begin
               tbl   = grid[3] ? grid_tbl_hi : grid_tbl_lo;
               entry = tbl[5*grid[2:0] +: 5];
               if (entry >= GRID_SPAN) return;
               addr = entry[3:0];
            end
            seg_out = segs;
            if (map_seg_en) begin
               // Colliding target positions OR together.
               seg_out = 8'h00;
               for (int i = 0; i < 8; i++)
                  if (segs[i]) seg_out[seg_tbl[3*i +: 3]] = 1'b1;
            end
            put_start();
            put_byte(BYTE_ADDR | {4'h0, addr});
            put_byte(seg_out);
            put_stop();
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Shared helpers
   // ------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [39:0] random_grid_tbl();
      logic [39:0] tbl;
      // One entry in four points outside the grid range.
      for (int k = 0; k < 8; k++)
         tbl[5*k +: 5] = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(16, 31))
                                                     : 5'($urandom_range(0, 15));
      return tbl;
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
   endfunction

   function automatic void check_field(input string name, input logic want, input logic got);
      if (got !== want)
         note_mismatch($sformatf("%s mismatch: expected %b, got %b", name, want, got));
   endfunction

   // Offer one request and wait for its accept. valid stays up when the next
   // request follows with no gap, so it is never dropped and raised in one step.
   task automatic send_request(input logic [1:0] cmd, input logic signed [4:0] bri,
                               input logic [7:0] grid, input logic [7:0] segs);
      repeat (gap_ahead) @(posedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.brightness <= bri;
      req_ch.grid       <= grid;
      req_ch.segs       <= segs;
      do @(posedge clock); while (!req_ch.ready);
      predict_frame(cmd, bri, grid, segs);
      gap_ahead = sender_idle ? pick_gap() : 0;
      if (gap_ahead != 0) req_ch.valid <= 1'b0;
   endtask

   // Stop offering, let every owed beat arrive, then allow for a dropped request.
   task automatic drain_frames();
      if (gap_ahead == 0) begin
         req_ch.valid <= 1'b0;
         gap_ahead = 1;
      end
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [39:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_GRID_MAP_EN:    map_grid_en = value[0];
         CSR_GRID_MAP_LOWER: grid_tbl_lo = value;
         CSR_GRID_MAP_UPPER: grid_tbl_hi = value;
         CSR_SEG_MAP_EN:     map_seg_en  = value[0];
         CSR_SEG_MAP:        seg_tbl     = value[23:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Only called with the block idle; writes back to back, then releases the port.
   task automatic program_maps(input logic gme, input logic [39:0] lo, input logic [39:0] hi,
                               input logic sme, input logic [23:0] smap);
      write_csr(CSR_GRID_MAP_EN, {39'd0, gme});
      write_csr(CSR_GRID_MAP_LOWER, lo);
      write_csr(CSR_GRID_MAP_UPPER, hi);
      write_csr(CSR_SEG_MAP_EN, {39'd0, sme});
      write_csr(CSR_SEG_MAP, {16'd0, smap});
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every command, brightness saturation on both sides, grid range edges,
   // ignored fields and the meaningless command three. Maps at reset values.
   task automatic test_directed_frames();
      send_request(CMD_BEGIN, 5'sd0, 8'd0, 8'd0);
      send_request(CMD_BEGIN, 5'sd15, 8'hFF, 8'hFF);   // unused fields ignored
      send_request(CMD_BRIGHT, -5'sd16, 8'd0, 8'd0);   // saturates to off
      send_request(CMD_BRIGHT, -5'sd1, 8'hFF, 8'hFF);
      send_request(CMD_BRIGHT, 5'sd0, 8'd0, 8'd0);
      send_request(CMD_BRIGHT, 5'sd1, 8'd0, 8'd0);
      send_request(CMD_BRIGHT, 5'sd8, 8'd0, 8'd0);
      send_request(CMD_BRIGHT, 5'sd9, 8'd0, 8'd0);     // clipped to eight
      send_request(CMD_BRIGHT, 5'sd15, 8'd0, 8'd0);
      send_request(CMD_GRID, 5'sd0, 8'd0, 8'h00);
      send_request(CMD_GRID, -5'sd1, 8'd15, 8'hFF);
      send_request(CMD_GRID, 5'sd3, 8'd7, 8'hA5);
      send_request(CMD_GRID, 5'sd0, 8'd16, 8'h5A);     // out of range, no frame
      send_request(CMD_GRID, 5'sd0, 8'hFF, 8'hFF);     // out of range, no frame
      send_request(CMD_SPARE, -5'sd1, 8'hFF, 8'hFF);   // ignored
      drain_frames();
   endtask

   // Grid remap with valid and invalid entries, segment remap with all bits
   // colliding, then a bit-reversing segment map.
   task automatic test_grid_remap();
      program_maps(1'b1,
                   {5'd0, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd16, 5'd15},
                   {5'd1, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10, 5'd9, 5'd31},
                   1'b1, 24'h000000);
      send_request(CMD_GRID, 5'sd0, 8'd0, 8'h81);   // maps to grid 15
      send_request(CMD_GRID, 5'sd0, 8'd1, 8'hFF);   // invalid entry, no frame
      send_request(CMD_GRID, 5'sd0, 8'd8, 8'hFF);   // invalid entry, no frame
      send_request(CMD_GRID, 5'sd0, 8'd15, 8'h3C);  // maps to grid 1
      send_request(CMD_GRID, 5'sd0, 8'd3, 8'hFF);   // all bits land on bit 0
      drain_frames();
      program_maps(1'b0, 40'd0, 40'd0, 1'b1,
                   {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7});
      send_request(CMD_GRID, 5'sd0, 8'd2, 8'h0F);
      drain_frames();
   endtask

   // Receiver stalls for a long stretch while requests keep coming back to
   // back, so the block fills up and holds off its input.
   task automatic test_backpressure();
      program_maps(1'b0, 40'd0, 40'd0, 1'b0, 24'd0);
      sender_idle = 1'b0;
      hold_cycles = HOLD_OFF;
      for (int i = 0; i < 8; i++)
         send_request(CMD_GRID, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)));
      sender_idle = 1'b1;
      drain_frames();
   endtask

   // Random requests over several register settings and idling mixes.
   task automatic test_random_traffic();
      int unsigned n_items;
      int unsigned r;
      logic [1:0]  cmd;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               program_maps(1'b0, 40'd0, 40'd0, 1'b0, 24'd0);
               sender_idle = 1'b1; drain_idle = 1'b1; n_items = 50;
            end
            3: begin
               // Everything set: every grid entry is invalid, so few frames.
               program_maps(1'b1, {40{1'b1}}, {40{1'b1}}, 1'b1, 24'hFFFFFF);
               sender_idle = 1'b1; drain_idle = 1'b1; n_items = 15;
            end
            default: begin
               program_maps(1'($urandom_range(0, 1)), random_grid_tbl(), random_grid_tbl(),
                            1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFFFFFF)));
               sender_idle = (phase != 1 && phase != 5);
               drain_idle  = (phase != 1 && phase != 4);
               n_items = (phase == 2) ? 50 : 45;
            end
         endcase
         for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            cmd = (r < 60) ? CMD_GRID : (r < 78) ? CMD_BRIGHT : (r < 94) ? CMD_BEGIN : CMD_SPARE;
            send_request(cmd, 5'($urandom_range(0, 31)),
                         ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
         end
         drain_frames();
      end
      sender_idle = 1'b1;
      drain_idle  = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Receiver: random ready stretches, or one long hold-off on request
   // ------------------------------------------------------------------

   initial begin : rsp_ready_drive
      int unsigned stretch;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_cycles != 0) begin
            stretch = hold_cycles;
            hold_cycles = 0;
            rsp_ch.ready <= 1'b0;
         end else if (!drain_idle || $urandom_range(0, 3) != 0) begin
            stretch = drain_idle ? $urandom_range(1, 8) : 1;
            rsp_ch.ready <= 1'b1;
         end else begin
            stretch = pick_gap() + 1;
            rsp_ch.ready <= 1'b0;
         end
         repeat (stretch) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Beat checker: each accepted beat against the oldest owed one
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      pin_step_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_steps.size() == 0) begin
            note_mismatch($sformatf("beat with none owed: clk=%b dat=%b hold=%b last=%b",
                                    rsp_ch.clock_level, rsp_ch.data_level,
                                    rsp_ch.hold_after, rsp_ch.last_step));
         end else begin
            want = pending_steps.pop_front();
            check_field("clock_level", want.clock_level, rsp_ch.clock_level);
            check_field("data_level", want.data_level, rsp_ch.data_level);
            check_field("hold_after", want.hold_after, rsp_ch.hold_after);
            check_field("last_step", want.last_step, rsp_ch.last_step);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.command    = CMD_BEGIN;
      req_ch.brightness = 5'sd0;
      req_ch.grid       = 8'd0;
      req_ch.segs       = 8'd0;
      csr_we            = 1'b0;
      csr_index         = CSR_GRID_MAP_EN;
      csr_wdata         = '0;
      map_grid_en       = 1'b0;
      grid_tbl_lo       = '0;
      grid_tbl_hi       = '0;
      map_seg_en        = 1'b0;
      seg_tbl           = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_grid_remap();
      test_backpressure();
      test_random_traffic();
      drain_frames();

      if (mismatch_count == 0 && pending_steps.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ledss_pkg.sv
rtl/core/ledss_if.sv
rtl/core/ledss_seq.sv
rtl/core/ledss_datapath.sv
rtl/core/led_driver_serial_sender_core.sv
bench/testbench.sv
